// ===== hdl/cave_smth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cave_smth_pkg;

   // Grid geometry
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
   localparam int X_W        = $clog2(MAX_WIDTH);
   localparam int Y_W        = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int DIM_W      = X_W + 1;
   localparam int DIM_H_W    = Y_W + 1;

   // Item fields
   localparam int CMD_W        = 2;
   localparam int INDEX_W      = 12;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 8;

   // Configuration port
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 7;
   localparam int SIZE_REG_W   = 7;
   localparam int LIMIT_REG_W  = 4;
   localparam int GEN_REG_W    = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_MAP_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BIRTH_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEATH_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GEN_COUNT   = 3'd4;

   localparam logic [SIZE_REG_W-1:0]  RST_MAP_WIDTH   = 7'd64;
   localparam logic [SIZE_REG_W-1:0]  RST_MAP_HEIGHT  = 7'd64;
   localparam logic [LIMIT_REG_W-1:0] RST_BIRTH_LIMIT = 4'd5;
   localparam logic [LIMIT_REG_W-1:0] RST_DEATH_LIMIT = 4'd4;
   localparam logic [GEN_REG_W-1:0]   RST_GEN_COUNT   = 4'd4;

   // Commands
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   // Neighborhood taps, row-major over the 3x3 window
   localparam int TAP_W = 4;
   localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;
   localparam logic [TAP_W-1:0] TAP_END    = 4'd9;
   localparam int CNT_W = 4;

endpackage

`default_nettype wire

// ===== hdl/cellular_automaton_cave_smoother_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cave smoother: binary grid (open 0 / blocked 1) with a Moore-neighborhood automaton.
// req channel carries commands: load a cell, run the generations plus border, read a cell.
// rsp channel returns exactly one item per command (read_value, run_done).
// csr port writes width, height, birth/death limits and generation count; write it
// only while the block is idle.
// Load and unused commands respond from the response register, and a new item can be taken
// every cycle while rsp is not stalled; a read first passes the synchronous memory read
// (ST_READ), and a run responds after its generations and the border sweep.
// A run visits every cell once per generation and reads its 3x3 window through the
// single read port of the source bank, one tap after another, then writes the result to
// the other bank; a final sweep over the grid writes the blocked border.
// Reset restores the register defaults and selects the first bank; grid contents are
// undefined until loaded. A stalled rsp holds its item and req is not taken until the
// response register can accept the next result.
module cellular_automaton_cave_smoother_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // [1:0] cmd, [13:2] cell_index, [14] cell_value, [15] zero
   input  wire logic [cave_smth_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // [0] read_value, [1] run_done, [7:2] zero
   output logic [cave_smth_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                                   csr_we,
   input  wire logic [cave_smth_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [cave_smth_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cave_smth_pkg::*;

   localparam int LIM_W  = DIM_W + DIM_H_W;
   localparam int PROD_W = Y_W + DIM_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_GEN    = 2'd2;
   localparam logic [1:0] ST_BORDER = 2'd3;

   // Configuration
   logic [SIZE_REG_W-1:0]  width_ff, height_ff;
   logic [LIMIT_REG_W-1:0] birth_ff, death_ff;
   logic [GEN_REG_W-1:0]   gen_count_ff;

   // Control and datapath state
   logic [1:0]        state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_read_ff, rsp_read_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              front_sel_ff, front_sel_in;
   logic [GEN_REG_W-1:0] gen_left_ff, gen_left_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [Y_W-1:0]    y_ff, y_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [TAP_W-1:0]  tap_ff, tap_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              center_ff, center_in;
   logic              oob_ff, oob_in;
   logic              rd_oor_ff, rd_oor_in;

   // Grid banks
   logic bank0_mem [0:CELL_COUNT-1];
   logic bank1_mem [0:CELL_COUNT-1];
   logic bank0_q_ff, bank1_q_ff;

   logic              wr_en, wr_bank, wr_bit;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   logic [DIM_W-1:0]   eff_w;
   logic [DIM_H_W-1:0] eff_h;
   logic [LIM_W-1:0]   cell_limit;

   logic [CMD_W-1:0]   req_cmd;
   logic [INDEX_W-1:0] req_index;
   logic               req_value;
   logic               req_accept;
   logic               idx_in_range;

   logic [1:0]         dx1, dy1;
   logic [DIM_W-1:0]   nx1;
   logic [DIM_H_W-1:0] ny1;
   logic [X_W-1:0]     nx;
   logic [Y_W-1:0]     ny;
   logic [PROD_W-1:0]  tap_row;
   logic [ADDR_W-1:0]  tap_addr;
   logic               tap_oob;

   logic               src_bit;
   logic               tap_add;
   logic [CNT_W-1:0]   cnt_sum;
   logic               new_cell;
   logic               last_x, last_y, on_border;

   // Effective geometry: zero is one, above the maximum is the maximum
   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = DIM_H_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = DIM_H_W'(MAX_HEIGHT);
      end else begin
         eff_h = DIM_H_W'(height_ff);
      end
   end

   assign cell_limit = LIM_W'(eff_w) * LIM_W'(eff_h);

   assign req_cmd      = req_tdata[CMD_W-1:0];
   assign req_index    = req_tdata[CMD_W+INDEX_W-1:CMD_W];
   assign req_value    = req_tdata[CMD_W+INDEX_W];
   assign req_tready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept   = req_tvalid && req_tready;
   assign idx_in_range = LIM_W'(req_index) < cell_limit;

   // Window tap offsets, each biased by one
   always_comb begin
      case (tap_ff)
         4'd0, 4'd1, 4'd2: dy1 = 2'd0;
         4'd3, 4'd4, 4'd5: dy1 = 2'd1;
         default:          dy1 = 2'd2;
      endcase
      case (tap_ff)
         4'd0, 4'd3, 4'd6: dx1 = 2'd0;
         4'd1, 4'd4, 4'd7: dx1 = 2'd1;
         default:          dx1 = 2'd2;
      endcase
   end

   assign nx1      = DIM_W'(x_ff) + DIM_W'(dx1);
   assign ny1      = DIM_H_W'(y_ff) + DIM_H_W'(dy1);
   assign tap_oob  = (nx1 == '0) || (nx1 > eff_w) || (ny1 == '0) || (ny1 > eff_h);
   assign nx       = X_W'(nx1 - DIM_W'(1));
   assign ny       = Y_W'(ny1 - DIM_H_W'(1));
   assign tap_row  = PROD_W'(ny) * PROD_W'(eff_w);
   assign tap_addr = ADDR_W'(tap_row) + ADDR_W'(nx);

   assign rd_addr = (state_ff == ST_IDLE) ? ADDR_W'(req_index) : tap_addr;
   assign src_bit = front_sel_ff ? bank1_q_ff : bank0_q_ff;

   // Read data of tap (tap_ff - 1) arrives now; the center does not count
   assign tap_add  = (tap_ff != '0) && (tap_ff != TAP_CENTER + TAP_W'(1)) && (oob_ff | src_bit);
   assign cnt_sum  = cnt_ff + CNT_W'(tap_add);
   assign new_cell = center_ff ? (cnt_sum >= CNT_W'(death_ff)) : (cnt_sum > CNT_W'(birth_ff));

   assign last_x    = DIM_W'(x_ff) == eff_w - DIM_W'(1);
   assign last_y    = DIM_H_W'(y_ff) == eff_h - DIM_H_W'(1);
   assign on_border = (x_ff == '0) || (y_ff == '0) || last_x || last_y;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_read_in  = rsp_read_ff;
      rsp_done_in  = rsp_done_ff;
      front_sel_in = front_sel_ff;
      gen_left_in  = gen_left_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      addr_in      = addr_ff;
      tap_in       = tap_ff;
      cnt_in       = cnt_ff;
      center_in    = center_ff;
      oob_in       = oob_ff;
      rd_oor_in    = rd_oor_ff;
      wr_en        = 1'b0;
      wr_bank      = front_sel_ff;
      wr_addr      = addr_ff;
      wr_bit       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_cmd)
                  CMD_LOAD: begin
                     wr_en        = idx_in_range;
                     wr_addr      = ADDR_W'(req_index);
                     wr_bit       = req_value;
                     rsp_valid_in = 1'b1;
                     rsp_read_in  = 1'b0;
                     rsp_done_in  = 1'b0;
                  end
                  CMD_READ: begin
                     rd_oor_in = !idx_in_range;
                     state_in  = ST_READ;
                  end
                  CMD_RUN: begin
                     x_in        = '0;
                     y_in        = '0;
                     addr_in     = '0;
                     tap_in      = '0;
                     cnt_in      = '0;
                     gen_left_in = gen_count_ff;
                     state_in    = (gen_count_ff == '0) ? ST_BORDER : ST_GEN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_read_in  = 1'b0;
                     rsp_done_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_read_in  = !rd_oor_ff && src_bit;
            rsp_done_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_GEN: begin
            oob_in = tap_oob;
            if (tap_ff == TAP_CENTER + TAP_W'(1)) begin
               center_in = src_bit;
            end
            if (tap_ff == TAP_END) begin
               wr_en   = 1'b1;
               wr_bank = !front_sel_ff;
               wr_bit  = new_cell;
               cnt_in  = '0;
               tap_in  = '0;
               addr_in = addr_ff + ADDR_W'(1);
               if (last_x) begin
                  x_in = '0;
                  if (last_y) begin
                     y_in         = '0;
                     addr_in      = '0;
                     front_sel_in = !front_sel_ff;
                     gen_left_in  = gen_left_ff - GEN_REG_W'(1);
                     if (gen_left_ff == GEN_REG_W'(1)) begin
                        state_in = ST_BORDER;
                     end
                  end else begin
                     y_in = y_ff + Y_W'(1);
                  end
               end else begin
                  x_in = x_ff + X_W'(1);
               end
            end else begin
               tap_in = tap_ff + TAP_W'(1);
               cnt_in = cnt_sum;
            end
         end
         ST_BORDER: begin
            wr_en   = on_border;
            wr_bank = front_sel_ff;
            wr_bit  = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (last_x) begin
               x_in = '0;
               if (last_y) begin
                  y_in         = '0;
                  rsp_valid_in = 1'b1;
                  rsp_read_in  = 1'b0;
                  rsp_done_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  y_in = y_ff + Y_W'(1);
               end
            end else begin
               x_in = x_ff + X_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RST_MAP_WIDTH;
         height_ff    <= RST_MAP_HEIGHT;
         birth_ff     <= RST_BIRTH_LIMIT;
         death_ff     <= RST_DEATH_LIMIT;
         gen_count_ff <= RST_GEN_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAP_WIDTH:   width_ff     <= SIZE_REG_W'(csr_wdata);
            REG_MAP_HEIGHT:  height_ff    <= SIZE_REG_W'(csr_wdata);
            REG_BIRTH_LIMIT: birth_ff     <= LIMIT_REG_W'(csr_wdata);
            REG_DEATH_LIMIT: death_ff     <= LIMIT_REG_W'(csr_wdata);
            REG_GEN_COUNT:   gen_count_ff <= GEN_REG_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         front_sel_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         front_sel_ff <= front_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_ff <= rsp_read_in;
      rsp_done_ff <= rsp_done_in;
      gen_left_ff <= gen_left_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      addr_ff     <= addr_in;
      tap_ff      <= tap_in;
      cnt_ff      <= cnt_in;
      center_ff   <= center_in;
      oob_ff      <= oob_in;
      rd_oor_ff   <= rd_oor_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) begin
         bank0_mem[wr_addr] <= wr_bit;
      end
      bank0_q_ff <= bank0_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_bank) begin
         bank1_mem[wr_addr] <= wr_bit;
      end
      bank1_q_ff <= bank1_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-2){1'b0}}, rsp_done_ff, rsp_read_ff};

endmodule

`default_nettype wire
